FILE: design/rctl_pkg.sv
// Shared types and constants of the rate class level tracker.
`timescale 1ns / 1ps
`default_nettype none
package rctl_pkg;

	localparam int LVL_W     = 16;
	localparam int TIME_W    = 32;
	localparam int DLY_W     = 34;
	localparam int IDX_W     = 3;
	localparam int KSPAN_W   = 19;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [LVL_W-1:0] WINDOW_RST = 16'd10;
	localparam logic [LVL_W-1:0] MAX_RST    = 16'd5000;
	localparam logic [LVL_W-1:0] THR_NONE   = 16'd9999;
	localparam logic [LVL_W-1:0] IDLE_DIV   = 16'd10;

	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW = 3'd0,
		REG_CLEAR  = 3'd1,
		REG_ALERT  = 3'd2,
		REG_LIMIT  = 3'd3,
		REG_MAX    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_CLEAR  = 3'd0,
		MODE_ALERT  = 3'd1,
		MODE_LIMIT  = 3'd2,
		MODE_IDLE10 = 3'd3,
		MODE_IDLE30 = 3'd4,
		MODE_IDLE50 = 3'd5,
		MODE_IDLE70 = 3'd6,
		MODE_NONE   = 3'd7
	} mode_t;

	typedef struct packed {
		logic [LVL_W-1:0] window_size;
		logic [LVL_W-1:0] clear_level;
		logic [LVL_W-1:0] alert_level;
		logic [LVL_W-1:0] limit_level;
		logic [LVL_W-1:0] max_level;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_CALC = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage
`default_nettype wire

FILE: design/rctl_serdiv.sv
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module rctl_serdiv (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rctl_pkg::TIME_W-1:0]  dividend,
	input  wire logic [rctl_pkg::LVL_W-1:0]   divisor,
	output logic                              done,
	output logic      [rctl_pkg::TIME_W-1:0]  quotient
);

	logic [rctl_pkg::TIME_W-1:0]    quo_q;
	logic [rctl_pkg::LVL_W:0]       rem_q;
	logic [rctl_pkg::LVL_W-1:0]     dvs_q;
	logic [rctl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic [rctl_pkg::LVL_W:0]       trial;
	logic                           qbit;

	// shift the next dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q[rctl_pkg::LVL_W-1:0], quo_q[rctl_pkg::TIME_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == rctl_pkg::DIV_CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= rctl_pkg::DIV_CNT_W'(rctl_pkg::DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - rctl_pkg::DIV_CNT_W'(1);
				if (cnt_q == rctl_pkg::DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[rctl_pkg::TIME_W-2:0], qbit};
			rem_q <= qbit ? (trial - {1'b0, dvs_q}) : trial;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: design/rctl_cfg_regs.sv
// Configuration register file of the rate class level tracker.
`timescale 1ns / 1ps
`default_nettype none
module rctl_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [rctl_pkg::IDX_W-1:0] wr_idx,
	input  wire logic [rctl_pkg::LVL_W-1:0] wr_data,
	output rctl_pkg::cfg_t                  cfg,
	output logic                            max_wr
);

	rctl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size <= rctl_pkg::WINDOW_RST;
			cfg_q.clear_level <= '0;
			cfg_q.alert_level <= '0;
			cfg_q.limit_level <= '0;
			cfg_q.max_level   <= rctl_pkg::MAX_RST;
		end else if (wr_en) begin
			unique case (rctl_pkg::reg_idx_t'(wr_idx))
				rctl_pkg::REG_WINDOW: cfg_q.window_size <= wr_data;
				rctl_pkg::REG_CLEAR:  cfg_q.clear_level <= wr_data;
				rctl_pkg::REG_ALERT:  cfg_q.alert_level <= wr_data;
				rctl_pkg::REG_LIMIT:  cfg_q.limit_level <= wr_data;
				rctl_pkg::REG_MAX:    cfg_q.max_level   <= wr_data;
				default: ;
			endcase
		end
	end

	// a write of the cap also reloads the tracked level
	assign max_wr = wr_en && (wr_idx == rctl_pkg::REG_MAX);
	assign cfg    = cfg_q;

endmodule
`default_nettype wire

FILE: design/rate_class_level_tracker_unit.sv
// Top level of the rate class level tracker: control sequence, state and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: command, now_ms, limit_mode.
//   Output channel (out_valid/out_ready) gives one result per item: next_level,
//   threshold, delay_ms and below_threshold.
//   Configuration channel (cfg_valid/cfg_ready) writes register cfg_index with
//   cfg_data; cfg_ready is always high. Write only while no item is in flight.
// Sequence:
//   After its transfer an item passes through the bit-serial dividers (one
//   quotient bit per cycle), the collection of their results, the forming of
//   level and threshold, the delay multiply and the hand-over of the result to
//   the output register, which waits while that register is still full.
//   One item in work at a time: in_ready rises with the result load.
// Stall:
//   A result that is not taken holds in the output register; the next item is
//   accepted meanwhile and its result waits in the block until the register frees.
// Reset:
//   arst_n clears control state, loads the configuration reset values, sets the
//   tracked level to the cap (5000) and the stored tick to zero.
`timescale 1ns / 1ps
`default_nettype none
module rate_class_level_tracker_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              command,
	input  wire logic [rctl_pkg::TIME_W-1:0]       now_ms,
	input  wire logic [2:0]                        limit_mode,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [rctl_pkg::LVL_W-1:0]        next_level,
	output logic      [rctl_pkg::LVL_W-1:0]        threshold,
	output logic signed [rctl_pkg::DLY_W-1:0]      delay_ms,
	output logic                                   below_threshold,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rctl_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [rctl_pkg::LVL_W-1:0]        cfg_data
);

	rctl_pkg::state_t state_q;
	rctl_pkg::cfg_t   cfg;
	logic             max_wr;

	// tracked state
	logic [rctl_pkg::LVL_W-1:0]  lvl_store_q;
	logic [rctl_pkg::TIME_W-1:0] time_store_q;

	// item fields held for the whole computation
	logic                        cmd_q;
	logic [rctl_pkg::TIME_W-1:0] now_q;
	rctl_pkg::mode_t             mode_q;

	// intermediate results
	logic [rctl_pkg::LVL_W-1:0]       lvl_q;
	logic [rctl_pkg::LVL_W-1:0]       thr_q;
	logic signed [rctl_pkg::LVL_W:0]  diff_q;
	logic [rctl_pkg::LVL_W-1:0]       res_lvl_q;
	logic [rctl_pkg::LVL_W-1:0]       res_thr_q;
	logic signed [rctl_pkg::DLY_W-1:0] res_dly_q;
	logic                             res_below_q;

	// output register
	logic                             out_valid_q;
	logic [rctl_pkg::LVL_W-1:0]       out_lvl_q;
	logic [rctl_pkg::LVL_W-1:0]       out_thr_q;
	logic signed [rctl_pkg::DLY_W-1:0] out_dly_q;
	logic                             out_below_q;

	logic                             in_xfer;
	logic                             out_load;
	logic [rctl_pkg::LVL_W-1:0]       w_eff;
	logic [rctl_pkg::LVL_W-1:0]       w_m1;
	logic [rctl_pkg::LVL_W-1:0]       span;
	logic [2:0]                       kmul;
	logic [rctl_pkg::TIME_W-1:0]      dvd_lvl;
	logic [rctl_pkg::TIME_W-1:0]      dvd_elap;
	logic [rctl_pkg::KSPAN_W-1:0]     kspan;
	logic [rctl_pkg::TIME_W-1:0]      quo_lvl;
	logic [rctl_pkg::TIME_W-1:0]      quo_elap;
	logic [rctl_pkg::TIME_W-1:0]      quo_idle;
	rctl_pkg::div_ctl_t               div_a;
	rctl_pkg::div_ctl_t               div_b;
	rctl_pkg::div_ctl_t               div_c;
	logic [rctl_pkg::TIME_W:0]        lvl_sum;
	logic [rctl_pkg::LVL_W-1:0]       lvl_cap;
	logic [rctl_pkg::LVL_W-1:0]       thr_sel;
	logic signed [rctl_pkg::DLY_W-1:0] dly_prod;

	rctl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg),
		.max_wr  (max_wr)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == rctl_pkg::ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_load  = (state_q == rctl_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// a zero window acts as a window of one
	assign w_eff = (cfg.window_size == '0) ? rctl_pkg::LVL_W'(1) : cfg.window_size;
	assign w_m1  = w_eff - rctl_pkg::LVL_W'(1);

	// idle thresholds use the span between clear and cap, floored at zero
	assign span = (cfg.max_level > cfg.clear_level) ? (cfg.max_level - cfg.clear_level) : '0;

	always_comb begin
		unique case (rctl_pkg::mode_t'(limit_mode))
			rctl_pkg::MODE_IDLE10: kmul = 3'd1;
			rctl_pkg::MODE_IDLE30: kmul = 3'd3;
			rctl_pkg::MODE_IDLE50: kmul = 3'd5;
			rctl_pkg::MODE_IDLE70: kmul = 3'd7;
			default:               kmul = 3'd0;
		endcase
	end

	// dividend operands, taken at the input transfer
	assign dvd_lvl  = {16'b0, lvl_store_q} * {16'b0, w_m1};
	assign dvd_elap = now_ms - time_store_q;
	assign kspan    = {3'b0, span} * {16'b0, kmul};

	assign div_a.start = in_xfer;
	assign div_b.start = in_xfer;
	assign div_c.start = in_xfer;

	rctl_serdiv u_div_lvl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_a.start),
		.dividend (dvd_lvl),
		.divisor  (w_eff),
		.done     (div_a.done),
		.quotient (quo_lvl)
	);

	rctl_serdiv u_div_elap (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_b.start),
		.dividend (dvd_elap),
		.divisor  (w_eff),
		.done     (div_b.done),
		.quotient (quo_elap)
	);

	rctl_serdiv u_div_idle (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_c.start),
		.dividend ({{(rctl_pkg::TIME_W - rctl_pkg::KSPAN_W){1'b0}}, kspan}),
		.divisor  (rctl_pkg::IDLE_DIV),
		.done     (div_c.done),
		.quotient (quo_idle)
	);

	// level: sum of the two quotients, capped at the configured max
	assign lvl_sum = {1'b0, quo_lvl} + {1'b0, quo_elap};
	assign lvl_cap = (lvl_sum > {17'b0, cfg.max_level}) ? cfg.max_level
	                                                      : lvl_sum[rctl_pkg::LVL_W-1:0];

	always_comb begin
		unique case (mode_q)
			rctl_pkg::MODE_CLEAR: thr_sel = cfg.clear_level;
			rctl_pkg::MODE_ALERT: thr_sel = cfg.alert_level;
			rctl_pkg::MODE_LIMIT: thr_sel = cfg.limit_level;
			rctl_pkg::MODE_IDLE10,
			rctl_pkg::MODE_IDLE30,
			rctl_pkg::MODE_IDLE50,
			rctl_pkg::MODE_IDLE70:
				thr_sel = cfg.clear_level + quo_idle[rctl_pkg::LVL_W-1:0];
			default:              thr_sel = rctl_pkg::THR_NONE;
		endcase
	end

	assign dly_prod = rctl_pkg::DLY_W'(diff_q) * rctl_pkg::DLY_W'($signed({1'b0, w_eff}));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rctl_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				rctl_pkg::ST_IDLE: if (in_xfer) state_q <= rctl_pkg::ST_DIV;
				rctl_pkg::ST_DIV:  if (div_a.done) state_q <= rctl_pkg::ST_CALC;
				rctl_pkg::ST_CALC: state_q <= rctl_pkg::ST_MUL;
				rctl_pkg::ST_MUL:  state_q <= rctl_pkg::ST_DONE;
				rctl_pkg::ST_DONE: if (out_load) state_q <= rctl_pkg::ST_IDLE;
				default:           state_q <= rctl_pkg::ST_IDLE;
			endcase
		end
	end

	// tracked level and tick: advance on a sent packet, reload the level on a cap write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_store_q  <= rctl_pkg::MAX_RST;
			time_store_q <= '0;
		end else if (max_wr) begin
			lvl_store_q <= cfg_data;
		end else if (out_load && cmd_q) begin
			lvl_store_q  <= res_lvl_q;
			time_store_q <= now_q;
		end
	end

	// item capture and datapath stages
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q  <= command;
			now_q  <= now_ms;
			mode_q <= rctl_pkg::mode_t'(limit_mode);
		end
		if (state_q == rctl_pkg::ST_CALC) begin
			lvl_q  <= lvl_cap;
			thr_q  <= thr_sel;
			diff_q <= $signed({1'b0, thr_sel}) - $signed({1'b0, lvl_store_q});
		end
		if (state_q == rctl_pkg::ST_MUL) begin
			res_lvl_q   <= lvl_q;
			res_thr_q   <= thr_q;
			res_dly_q   <= dly_prod + $signed({18'b0, lvl_store_q});
			res_below_q <= (lvl_q < thr_q);
		end
		if (out_load) begin
			out_lvl_q   <= res_lvl_q;
			out_thr_q   <= res_thr_q;
			out_dly_q   <= res_dly_q;
			out_below_q <= res_below_q;
		end
	end

	// output register: hold until the transfer, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign next_level      = out_lvl_q;
	assign threshold       = out_thr_q;
	assign delay_ms        = out_dly_q;
	assign below_threshold = out_below_q;

endmodule
`default_nettype wire

FILE: design/rctl_checker.sv
// Port-level checks of the rate class level tracker and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rctl_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [rctl_pkg::LVL_W-1:0]         next_level,
	input wire logic [rctl_pkg::LVL_W-1:0]         threshold,
	input wire logic signed [rctl_pkg::DLY_W-1:0]  delay_ms,
	input wire logic                               below_threshold
);

	// one item in work at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input still ready right after a transfer");

	// a fresh result comes only from a busy block
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");

	// flag agrees with the delivered level and threshold
	a_below_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (below_threshold == (next_level < threshold)))
		else $error("below_threshold disagrees with next_level and threshold");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(next_level) && $stable(threshold)
			 && $stable(delay_ms) && $stable(below_threshold)))
		else $error("stalled result changed");

endmodule

bind rate_class_level_tracker_unit rctl_checker u_rctl_checker (.*);
`default_nettype wire

FILE: verif/tb_rate_class_level_tracker_unit.sv
// Self-checking testbench for the rate class level tracker unit.
`timescale 1ns / 1ps
module tb_rate_class_level_tracker_unit;

	// Register indexes past the last register; writes there must change nothing.
	localparam logic [rctl_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [rctl_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int RUN_LIMIT     = 800000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 130;
	localparam int REGIME_SPAN   = 440;
	localparam int CFG_QUIET     = 4;
	localparam int SETTLE_CYCLES = 40;

	// One result of the block, packed the way the checker compares it.
	typedef struct packed {
		logic [rctl_pkg::LVL_W-1:0] level;
		logic [rctl_pkg::LVL_W-1:0] thr;
		logic [rctl_pkg::DLY_W-1:0] delay;
		logic                       below;
	} outcome_t;

	// One row of the directed script: a register write or a packet.
	typedef struct packed {
		logic                        is_write;
		logic [rctl_pkg::IDX_W-1:0]  idx;
		logic [rctl_pkg::LVL_W-1:0]  data;
		logic                        cmd;
		logic [rctl_pkg::TIME_W-1:0] now;
		logic [2:0]                  mode;
		logic                        known;
		outcome_t                    want;
	} script_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic                              command;
	logic [rctl_pkg::TIME_W-1:0]       now_ms;
	logic [2:0]                        limit_mode;
	logic                              out_valid;
	logic                              out_ready;
	logic [rctl_pkg::LVL_W-1:0]        next_level;
	logic [rctl_pkg::LVL_W-1:0]        threshold;
	logic signed [rctl_pkg::DLY_W-1:0] delay_ms;
	logic                              below_threshold;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [rctl_pkg::IDX_W-1:0]        cfg_index;
	logic [rctl_pkg::LVL_W-1:0]        cfg_data;

	// Shadow copy of the registers and the tracked state.
	logic [rctl_pkg::LVL_W-1:0]  win_r;
	logic [rctl_pkg::LVL_W-1:0]  clear_r;
	logic [rctl_pkg::LVL_W-1:0]  alert_r;
	logic [rctl_pkg::LVL_W-1:0]  limit_r;
	logic [rctl_pkg::LVL_W-1:0]  max_r;
	logic [rctl_pkg::LVL_W-1:0]  level_r;
	logic [rctl_pkg::TIME_W-1:0] tick_r;

	outcome_t    levels_due[$];
	script_row_t script[$];

	int  errors       = 0;
	int  cycle_count  = 0;
	int  packets_sent = 0;
	int  snd_idle_pct = 28;
	int  rcv_idle_pct = 84;
	bit  in_flight    = 1'b0;

	rate_class_level_tracker_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.now_ms          (now_ms),
		.limit_mode      (limit_mode),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.next_level      (next_level),
		.threshold       (threshold),
		.delay_ms        (delay_ms),
		.below_threshold (below_threshold),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("** rate_class_level_tracker_unit: FAILED **");
			$finish;
		end
	end

	// Result side: drop ready at random according to the current regime.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	// Projected level, threshold, delay and flag for one packet, from the shadow
	// state as it stands before the packet. The products are formed in 64 bits.
	function automatic outcome_t project_level(input logic [rctl_pkg::TIME_W-1:0] now,
			input logic [2:0] mode);
		logic [63:0]                 w;
		logic [63:0]                 lvl;
		logic [63:0]                 span;
		logic [63:0]                 thr;
		logic [rctl_pkg::TIME_W-1:0] elapsed;
		longint                      dly;
		outcome_t                    o;
		w       = (win_r == '0) ? 64'd1 : {48'd0, win_r};
		elapsed = now - tick_r;
		lvl     = ({48'd0, level_r} * (w - 64'd1)) / w + {32'd0, elapsed} / w;
		if (lvl > {48'd0, max_r})
			lvl = {48'd0, max_r};
		// Clear above the cap leaves no span, so the idle levels sit at clear.
		span = (max_r > clear_r) ? {48'd0, max_r - clear_r} : 64'd0;
		case (rctl_pkg::mode_t'(mode))
			rctl_pkg::MODE_CLEAR:  thr = {48'd0, clear_r};
			rctl_pkg::MODE_ALERT:  thr = {48'd0, alert_r};
			rctl_pkg::MODE_LIMIT:  thr = {48'd0, limit_r};
			rctl_pkg::MODE_IDLE10: thr = {48'd0, clear_r} + span / 10;
			rctl_pkg::MODE_IDLE30: thr = {48'd0, clear_r} + (3 * span) / 10;
			rctl_pkg::MODE_IDLE50: thr = {48'd0, clear_r} + span / 2;
			rctl_pkg::MODE_IDLE70: thr = {48'd0, clear_r} + (7 * span) / 10;
			default:               thr = {48'd0, rctl_pkg::THR_NONE};
		endcase
		dly = (longint'(thr) - longint'(level_r)) * longint'(w) + longint'(level_r);
		o.level = lvl[rctl_pkg::LVL_W-1:0];
		o.thr   = thr[rctl_pkg::LVL_W-1:0];
		o.delay = rctl_pkg::DLY_W'(dly);
		o.below = (lvl[rctl_pkg::LVL_W-1:0] < thr[rctl_pkg::LVL_W-1:0]);
		return o;
	endfunction

	function automatic script_row_t row_packet(input logic cmd,
			input logic [rctl_pkg::TIME_W-1:0] now, input logic [2:0] mode);
		script_row_t r;
		r      = '0;
		r.cmd  = cmd;
		r.now  = now;
		r.mode = mode;
		return r;
	endfunction

	// Packet row whose result is typed in by hand.
	function automatic script_row_t row_known(input logic cmd,
			input logic [rctl_pkg::TIME_W-1:0] now, input logic [2:0] mode,
			input int lvl, input int thr, input longint dly, input logic below);
		script_row_t r;
		r             = row_packet(cmd, now, mode);
		r.known       = 1'b1;
		r.want.level  = rctl_pkg::LVL_W'(lvl);
		r.want.thr    = rctl_pkg::LVL_W'(thr);
		r.want.delay  = rctl_pkg::DLY_W'(dly);
		r.want.below  = below;
		return r;
	endfunction

	function automatic script_row_t row_write(input logic [rctl_pkg::IDX_W-1:0] idx,
			input logic [rctl_pkg::LVL_W-1:0] data);
		script_row_t r;
		r          = '0;
		r.is_write = 1'b1;
		r.idx      = idx;
		r.data     = data;
		return r;
	endfunction

	// Let every pending result come home, then hold the block quiet a while.
	task automatic settle_block(input int quiet);
		in_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (quiet) @(posedge clk);
		in_flight = 1'b0;
	endtask

	// Write one register, only once the block has gone idle.
	task automatic write_reg(input logic [rctl_pkg::IDX_W-1:0] idx,
			input logic [rctl_pkg::LVL_W-1:0] data);
		if (in_flight)
			settle_block(CFG_QUIET);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rctl_pkg::REG_WINDOW: win_r = data;
			rctl_pkg::REG_CLEAR:  clear_r = data;
			rctl_pkg::REG_ALERT:  alert_r = data;
			rctl_pkg::REG_LIMIT:  limit_r = data;
			// A new cap also restarts the tracked level at that cap.
			rctl_pkg::REG_MAX: begin
				max_r   = data;
				level_r = data;
			end
			default: ;
		endcase
	endtask

	// Offer one packet and, on its transfer, queue the expected result.
	task automatic offer_packet(input logic cmd, input logic [rctl_pkg::TIME_W-1:0] now,
			input logic [2:0] mode, input logic known, input outcome_t want);
		outcome_t pred;
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		now_ms     <= now;
		limit_mode <= mode;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = project_level(now, mode);
		levels_due.push_back(known ? want : pred);
		// A sent packet commits its level and tick for the next one.
		if (cmd) begin
			level_r = pred.level;
			tick_r  = now;
		end
		in_flight = 1'b1;
		packets_sent++;
		// Swap the idling sides, then run with no idling at all.
		if (packets_sent == REGIME_SPAN) begin
			snd_idle_pct = 84;
			rcv_idle_pct <= 28;
		end else if (packets_sent == 2 * REGIME_SPAN) begin
			snd_idle_pct = 0;
			rcv_idle_pct <= 0;
		end
	endtask

	function automatic logic [rctl_pkg::LVL_W-1:0] pick_window();
		case ($urandom_range(0, 6))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'd2;
			default: return rctl_pkg::LVL_W'($urandom_range(3, 64));
		endcase
	endfunction

	function automatic logic [rctl_pkg::LVL_W-1:0] pick_cap();
		case ($urandom_range(0, 5))
			0:       return 16'hFFFF;
			1:       return rctl_pkg::LVL_W'($urandom());
			default: return rctl_pkg::LVL_W'($urandom_range(100, 8000));
		endcase
	endfunction

	// Thresholds mostly under the cap so the level crosses them now and then.
	function automatic logic [rctl_pkg::LVL_W-1:0] pick_level(
			input logic [rctl_pkg::LVL_W-1:0] cap);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 16'hFFFF;
			default: return rctl_pkg::LVL_W'($urandom_range(0, cap));
		endcase
	endfunction

	// One random phase: fresh settings, then a run of packets whose ticks mostly
	// advance by up to one and a half times the cap, so the level drifts around the thresholds.
	task automatic run_phase(input int n_items);
		logic [rctl_pkg::LVL_W-1:0]  cap;
		logic [rctl_pkg::IDX_W-1:0]  spare;
		logic [rctl_pkg::TIME_W-1:0] clock_ms;
		logic [rctl_pkg::TIME_W-1:0] t;
		int unsigned                 reach;
		cap = pick_cap();
		write_reg(rctl_pkg::REG_WINDOW, pick_window());
		write_reg(rctl_pkg::REG_CLEAR, pick_level(cap));
		write_reg(rctl_pkg::REG_ALERT, pick_level(cap));
		write_reg(rctl_pkg::REG_LIMIT, pick_level(cap));
		write_reg(rctl_pkg::REG_MAX, cap);
		if ($urandom_range(0, 2) == 0) begin
			spare = REG_SPARE_LO + rctl_pkg::IDX_W'($urandom_range(0, 2));
			write_reg(spare, rctl_pkg::LVL_W'($urandom()));
		end
		// Start some phases just short of the tick counter wrap.
		if ($urandom_range(0, 3) == 0)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		else
			clock_ms = $urandom();
		repeat (n_items) begin
			reach = max_r + max_r / 2 + 16;
			case ($urandom_range(0, 11))
				0:       t = $urandom();
				1:       t = tick_r - $urandom_range(1, 5000);
				default: t = clock_ms + $urandom_range(0, reach);
			endcase
			clock_ms = t;
			offer_packet($urandom_range(0, 9) < 7, t, 3'($urandom_range(0, 7)), 1'b0, '0);
		end
	endtask

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : take_result
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (levels_due.size() == 0) begin
				report($sformatf("result with nothing expected: level %0d threshold %0d",
					next_level, threshold));
			end else begin
				want = levels_due.pop_front();
				if (next_level !== want.level)
					report($sformatf("next_level expected %0d got %0d", want.level, next_level));
				if (threshold !== want.thr)
					report($sformatf("threshold expected %0d got %0d", want.thr, threshold));
				if (delay_ms !== want.delay)
					report($sformatf("delay_ms expected %0d got %0d",
						$signed(want.delay), delay_ms));
				if (below_threshold !== want.below)
					report($sformatf("below_threshold expected %0b got %0b",
						want.below, below_threshold));
			end
		end
	end

	initial begin
		in_valid   <= 1'b0;
		command    <= 1'b0;
		now_ms     <= '0;
		limit_mode <= rctl_pkg::MODE_CLEAR;
		out_ready  <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= rctl_pkg::REG_WINDOW;
		cfg_data   <= '0;
		arst_n     <= 1'b0;

		win_r   = rctl_pkg::WINDOW_RST;
		clear_r = '0;
		alert_r = '0;
		limit_r = '0;
		max_r   = rctl_pkg::MAX_RST;
		level_r = rctl_pkg::MAX_RST;
		tick_r  = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight after reset: window 10, cap and level 5000, tick 0, other levels 0.
		script.push_back(row_known(1'b0, 32'd0, rctl_pkg::MODE_NONE,
			4500, 9999, 54990, 1'b1));
		script.push_back(row_known(1'b0, 32'd0, rctl_pkg::MODE_CLEAR,
			4500, 0, -45000, 1'b0));
		script.push_back(row_known(1'b0, 32'hFFFF_FFFF, rctl_pkg::MODE_LIMIT,
			5000, 0, -45000, 1'b0));
		script.push_back(row_known(1'b0, 32'd0, rctl_pkg::MODE_IDLE10,
			4500, 500, -40000, 1'b0));
		script.push_back(row_known(1'b0, 32'd0, rctl_pkg::MODE_IDLE70,
			4500, 3500, -10000, 1'b0));
		script.push_back(row_packet(1'b1, 32'd1000, rctl_pkg::MODE_ALERT));
		// Tick behind the stored one: elapsed time wraps.
		script.push_back(row_packet(1'b0, 32'd999, rctl_pkg::MODE_IDLE30));
		script.push_back(row_packet(1'b1, 32'd2000, rctl_pkg::MODE_IDLE50));
		// Zero window acts as one; clear above the cap.
		script.push_back(row_write(rctl_pkg::REG_WINDOW, 16'd0));
		script.push_back(row_write(rctl_pkg::REG_MAX, 16'd100));
		script.push_back(row_write(rctl_pkg::REG_CLEAR, 16'd200));
		script.push_back(row_write(rctl_pkg::REG_ALERT, 16'hFFFF));
		script.push_back(row_write(rctl_pkg::REG_LIMIT, 16'd50));
		script.push_back(row_packet(1'b1, 32'd5, rctl_pkg::MODE_IDLE30));
		script.push_back(row_packet(1'b0, 32'hFFFF_FFFF, rctl_pkg::MODE_ALERT));
		script.push_back(row_packet(1'b0, 32'd7, rctl_pkg::MODE_LIMIT));
		// Writes past the last register leave everything as it was.
		script.push_back(row_write(REG_SPARE_LO, 16'h1234));
		script.push_back(row_write(REG_SPARE_HI, 16'hFFFF));
		script.push_back(row_packet(1'b0, 32'd100, rctl_pkg::MODE_IDLE70));
		// Widest window and cap: most negative delay.
		script.push_back(row_write(rctl_pkg::REG_WINDOW, 16'hFFFF));
		script.push_back(row_write(rctl_pkg::REG_CLEAR, 16'd0));
		script.push_back(row_write(rctl_pkg::REG_MAX, 16'hFFFF));
		script.push_back(row_packet(1'b0, 32'd0, rctl_pkg::MODE_CLEAR));
		script.push_back(row_packet(1'b1, 32'h8000_0000, rctl_pkg::MODE_IDLE50));
		// Zero cap with the alert level at the top: largest delay.
		script.push_back(row_write(rctl_pkg::REG_MAX, 16'd0));
		script.push_back(row_packet(1'b0, 32'd12345, rctl_pkg::MODE_ALERT));
		script.push_back(row_packet(1'b1, 32'hFFFF_FFFF, rctl_pkg::MODE_NONE));
		script.push_back(row_write(rctl_pkg::REG_WINDOW, 16'd1));
		script.push_back(row_packet(1'b1, 32'd0, rctl_pkg::MODE_IDLE10));

		foreach (script[i]) begin
			if (script[i].is_write)
				write_reg(script[i].idx, script[i].data);
			else
				offer_packet(script[i].cmd, script[i].now, script[i].mode,
					script[i].known, script[i].want);
		end

		repeat (PHASES) run_phase(PHASE_ITEMS);

		// Drain, then give stray results time to show up.
		settle_block(SETTLE_CYCLES);
		if (levels_due.size() != 0)
			report($sformatf("%0d results never arrived", levels_due.size()));
		if (errors == 0)
			$display("** rate_class_level_tracker_unit: PASSED **");
		else
			$display("** rate_class_level_tracker_unit: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
design/rctl_pkg.sv
design/rctl_serdiv.sv
design/rctl_cfg_regs.sv
design/rate_class_level_tracker_unit.sv
design/rctl_checker.sv
verif/tb_rate_class_level_tracker_unit.sv
